// File: rtl/msc_pkg.sv
// shared types and constants for the merge sort block
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

   localparam int DATA_W = 32;
   localparam int CMP_W  = 16;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT,
      ST_FRAME,
      ST_MRG_RD,
      ST_MRG_LD,
      ST_MRG_CMP,
      ST_COPY,
      ST_POP,
      ST_EMIT_RD,
      ST_EMIT_WAIT
   } state_type;

   // what the segment on top of the stack still needs
   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_MERGE
   } phase_type;

endpackage
`default_nettype wire

// File: rtl/msc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module msc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [AddrW-1:0]      waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic [AddrW-1:0]      raddr,
   output      logic [WIDTH-1:0]      rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/merge_sort_with_compare_count.sv
// stable top-down merge sort of signed words with a merge comparison count
//
//   channel | dir | ports                                              | takes
//   req     | in  | req_valid req_stall req_value req_last_in          | one element
//   rsp     | out | rsp_valid rsp_stall rsp_sorted_value rsp_last_out   | one sorted element
//           |     | rsp_comparisons rsp_dropped                        |
//
// loading accepts one element per cycle; req_stall is low only while loading.
// the sort walks segments with an explicit stack; each merged element passes
// a compare state, then the next head of its run, if any, is fetched from the element
// ram (single read port) through a read and a load state; merged runs are copied
// back from the buffer ram, and each result goes out via a read and a wait state.
// reset is synchronous and clears the set; rams need no clearing.
// a stalled result holds its output register; emission waits until it drains.
`timescale 1ns / 1ps
`default_nettype none
module merge_sort_with_compare_count #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic signed [msc_pkg::DATA_W-1:0] req_value,
   input  wire logic                           req_last_in,
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic signed [msc_pkg::DATA_W-1:0] rsp_sorted_value,
   output      logic                           rsp_last_out,
   output      logic [msc_pkg::CMP_W-1:0]      rsp_comparisons,
   output      logic                           rsp_dropped
);
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int LW = $clog2(MAX_ITEMS + 1);
   localparam int SD = AW + 1;
   localparam int SW = $clog2(SD);
   localparam int DW = msc_pkg::DATA_W;
   localparam int CW = msc_pkg::CMP_W;

   msc_pkg::state_type state_ff, state_in;

   logic [LW-1:0] count_ff, count_in;
   logic [CW-1:0] cmp_ff, cmp_in;
   logic          ovf_ff, ovf_in;

   // top frame of the segment stack, rest in stk_*
   logic [LW-1:0]      top_lo_ff, top_lo_in;
   logic [LW-1:0]      top_len_ff, top_len_in;
   msc_pkg::phase_type top_ph_ff, top_ph_in;
   logic [SW-1:0]      sp_ff, sp_in;
   logic [LW-1:0]      stk_lo_ff [SD];
   logic [LW-1:0]      stk_len_ff [SD];
   msc_pkg::phase_type stk_ph_ff [SD];
   logic               stk_we;
   msc_pkg::phase_type stk_wph;

   logic [LW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, cw_ff, cw_in;
   logic [DW-1:0] head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic          sel_b_ff, sel_b_in, init_ff, init_in, cp_vld_ff, cp_vld_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]        rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [CW-1:0]        rsp_cmp_ff, rsp_cmp_in;
   logic                 rsp_drop_ff, rsp_drop_in;

   logic          st_we, bf_we;
   logic [AW-1:0] st_waddr, st_raddr, bf_waddr, bf_raddr;
   logic [DW-1:0] st_wdata, st_rdata, bf_wdata, bf_rdata;

   logic [LW:0]   len_p1;
   logic [LW-1:0] first, second, mid, end_j, k_nx, copy_addr;
   logic [SW-1:0] sp_top;
   logic          a_live, b_live, take_a, k_last, out_free, emit_last, has_room;

   assign len_p1    = {1'b0, top_len_ff} + {{LW{1'b0}}, 1'b1};
   assign first     = len_p1[LW:1];
   assign second    = top_len_ff - first;
   assign mid       = top_lo_ff + first;
   assign end_j     = top_lo_ff + top_len_ff;
   assign k_nx      = k_ff + LW'(1);
   assign copy_addr = top_lo_ff + cw_ff;
   assign sp_top    = sp_ff - SW'(1);
   assign a_live    = i_ff < mid;
   assign b_live    = j_ff < end_j;
   // ties go to the first run to keep the sort stable
   assign take_a    = a_live && (!b_live || ($signed(head_a_ff) <= $signed(head_b_ff)));
   assign k_last    = k_nx == top_len_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = k_nx == count_ff;
   assign has_room  = count_ff < LW'(MAX_ITEMS);

   msc_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   msc_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_buffer (
      .clock (clock),
      .we    (bf_we),
      .waddr (bf_waddr),
      .wdata (bf_wdata),
      .raddr (bf_raddr),
      .rdata (bf_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msc_pkg::ST_LOAD: begin
            if (req_valid && req_last_in) begin
               state_in = msc_pkg::ST_SORT;
            end
         end
         msc_pkg::ST_SORT: begin
            state_in = (count_ff <= LW'(1)) ? msc_pkg::ST_EMIT_RD : msc_pkg::ST_FRAME;
         end
         msc_pkg::ST_FRAME: begin
            if (top_ph_ff == msc_pkg::PH_MERGE) begin
               state_in = msc_pkg::ST_MRG_RD;
            end
         end
         msc_pkg::ST_MRG_RD: state_in = msc_pkg::ST_MRG_LD;
         msc_pkg::ST_MRG_LD: begin
            state_in = init_ff ? msc_pkg::ST_MRG_RD : msc_pkg::ST_MRG_CMP;
         end
         msc_pkg::ST_MRG_CMP: begin
            if (k_last) begin
               state_in = msc_pkg::ST_COPY;
            end else if (take_a && ((i_ff + LW'(1)) < mid)) begin
               state_in = msc_pkg::ST_MRG_RD;
            end else if (!take_a && ((j_ff + LW'(1)) < end_j)) begin
               state_in = msc_pkg::ST_MRG_RD;
            end
         end
         msc_pkg::ST_COPY: begin
            if (k_ff >= top_len_ff) begin
               state_in = msc_pkg::ST_POP;
            end
         end
         msc_pkg::ST_POP: begin
            state_in = (sp_ff == '0) ? msc_pkg::ST_EMIT_RD : msc_pkg::ST_FRAME;
         end
         msc_pkg::ST_EMIT_RD: state_in = msc_pkg::ST_EMIT_WAIT;
         msc_pkg::ST_EMIT_WAIT: begin
            if (out_free) begin
               state_in = emit_last ? msc_pkg::ST_LOAD : msc_pkg::ST_EMIT_RD;
            end
         end
         default: state_in = msc_pkg::ST_LOAD;
      endcase
   end

   // datapath and ram controls
   always_comb begin
      count_in   = count_ff;
      cmp_in     = cmp_ff;
      ovf_in     = ovf_ff;
      top_lo_in  = top_lo_ff;
      top_len_in = top_len_ff;
      top_ph_in  = top_ph_ff;
      sp_in      = sp_ff;
      stk_we     = 1'b0;
      stk_wph    = msc_pkg::PH_SECOND;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      cw_in      = cw_ff;
      head_a_in  = head_a_ff;
      head_b_in  = head_b_ff;
      sel_b_in   = sel_b_ff;
      init_in    = init_ff;
      cp_vld_in  = cp_vld_ff;
      st_we      = 1'b0;
      st_waddr   = count_ff[AW-1:0];
      st_wdata   = req_value;
      st_raddr   = k_ff[AW-1:0];
      bf_we      = 1'b0;
      bf_waddr   = k_ff[AW-1:0];
      bf_wdata   = take_a ? head_a_ff : head_b_ff;
      bf_raddr   = k_ff[AW-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_drop_in  = rsp_drop_ff;

      unique case (state_ff)
         msc_pkg::ST_LOAD: begin
            if (req_valid) begin
               if (has_room) begin
                  st_we    = 1'b1;
                  count_in = count_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         msc_pkg::ST_SORT: begin
            top_lo_in  = '0;
            top_len_in = count_ff;
            top_ph_in  = msc_pkg::PH_FIRST;
            sp_in      = '0;
            k_in       = '0;
         end
         msc_pkg::ST_FRAME: begin
            unique case (top_ph_ff)
               msc_pkg::PH_FIRST: begin
                  if (first > LW'(1)) begin
                     stk_we     = 1'b1;
                     stk_wph    = msc_pkg::PH_SECOND;
                     sp_in      = sp_ff + SW'(1);
                     top_len_in = first;
                  end else begin
                     top_ph_in = msc_pkg::PH_SECOND;
                  end
               end
               msc_pkg::PH_SECOND: begin
                  if (second > LW'(1)) begin
                     stk_we     = 1'b1;
                     stk_wph    = msc_pkg::PH_MERGE;
                     sp_in      = sp_ff + SW'(1);
                     top_lo_in  = mid;
                     top_len_in = second;
                     top_ph_in  = msc_pkg::PH_FIRST;
                  end else begin
                     top_ph_in = msc_pkg::PH_MERGE;
                  end
               end
               msc_pkg::PH_MERGE: begin
                  i_in     = top_lo_ff;
                  j_in     = mid;
                  k_in     = '0;
                  sel_b_in = 1'b0;
                  init_in  = 1'b1;
               end
               default: top_ph_in = msc_pkg::PH_FIRST;
            endcase
         end
         msc_pkg::ST_MRG_RD: begin
            st_raddr = sel_b_ff ? j_ff[AW-1:0] : i_ff[AW-1:0];
         end
         msc_pkg::ST_MRG_LD: begin
            st_raddr = sel_b_ff ? j_ff[AW-1:0] : i_ff[AW-1:0];
            if (sel_b_ff) begin
               head_b_in = st_rdata;
            end else begin
               head_a_in = st_rdata;
            end
            if (init_ff) begin
               sel_b_in = 1'b1;
               init_in  = 1'b0;
            end
         end
         msc_pkg::ST_MRG_CMP: begin
            bf_we = 1'b1;
            if (a_live && b_live && (cmp_ff != '1)) begin
               cmp_in = cmp_ff + CW'(1);
            end
            if (take_a) begin
               i_in = i_ff + LW'(1);
            end else begin
               j_in = j_ff + LW'(1);
            end
            sel_b_in = !take_a;
            if (k_last) begin
               k_in      = '0;
               cp_vld_in = 1'b0;
            end else begin
               k_in = k_nx;
            end
         end
         msc_pkg::ST_COPY: begin
            // read buffer at k, write the previous entry back to the store
            st_we    = cp_vld_ff;
            st_waddr = copy_addr[AW-1:0];
            st_wdata = bf_rdata;
            if (k_ff < top_len_ff) begin
               cp_vld_in = 1'b1;
               cw_in     = k_ff;
               k_in      = k_nx;
            end else begin
               cp_vld_in = 1'b0;
            end
         end
         msc_pkg::ST_POP: begin
            if (sp_ff != '0) begin
               top_lo_in  = stk_lo_ff[sp_top];
               top_len_in = stk_len_ff[sp_top];
               top_ph_in  = stk_ph_ff[sp_top];
               sp_in      = sp_top;
            end else begin
               k_in = '0;
            end
         end
         msc_pkg::ST_EMIT_RD: begin
            st_raddr = k_ff[AW-1:0];
         end
         msc_pkg::ST_EMIT_WAIT: begin
            st_raddr = k_ff[AW-1:0];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = st_rdata;
               rsp_last_in  = emit_last;
               rsp_cmp_in   = cmp_ff;
               rsp_drop_in  = ovf_ff;
               k_in         = k_nx;
               if (emit_last) begin
                  count_in = '0;
                  cmp_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            cp_vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msc_pkg::ST_LOAD;
         count_ff     <= '0;
         cmp_ff       <= '0;
         ovf_ff       <= 1'b0;
         sp_ff        <= '0;
         cp_vld_ff    <= 1'b0;
         init_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_ff       <= cmp_in;
         ovf_ff       <= ovf_in;
         sp_ff        <= sp_in;
         cp_vld_ff    <= cp_vld_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_lo_ff    <= top_lo_in;
      top_len_ff   <= top_len_in;
      top_ph_ff    <= top_ph_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      cw_ff        <= cw_in;
      head_a_ff    <= head_a_in;
      head_b_ff    <= head_b_in;
      sel_b_ff     <= sel_b_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_drop_ff  <= rsp_drop_in;
      if (stk_we) begin
         stk_lo_ff[sp_ff]  <= top_lo_ff;
         stk_len_ff[sp_ff] <= top_len_ff;
         stk_ph_ff[sp_ff]  <= stk_wph;
      end
   end

   assign req_stall        = state_ff != msc_pkg::ST_LOAD;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_comparisons  = rsp_cmp_ff;
   assign rsp_dropped      = rsp_drop_ff;

endmodule
`default_nettype wire

// File: rtl/msc_checker.sv
// port level checks for the merge sort block and their bind
`timescale 1ns / 1ps
`default_nettype none
module msc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          req_last_in,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [msc_pkg::DATA_W-1:0]    rsp_sorted_value,
   input wire logic                          rsp_last_out,
   input wire logic [msc_pkg::CMP_W-1:0]     rsp_comparisons,
   input wire logic                          rsp_dropped
);
   // a held result keeps its whole payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sorted_value)
         && $stable(rsp_last_out) && $stable(rsp_comparisons) && $stable(rsp_dropped))
      else $error("result changed while stalled");

   // the closing element of a set starts the sort, so input stops
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_in |=> req_stall)
      else $error("input taken right after the final element");

   // while a set is still being emitted no new element is taken
   a_emit_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |-> req_stall)
      else $error("input open during emission");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind merge_sort_with_compare_count msc_checker u_msc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_in      (req_last_in),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_out     (rsp_last_out),
   .rsp_comparisons  (rsp_comparisons),
   .rsp_dropped      (rsp_dropped)
);
`default_nettype wire

// File: tb/merge_sort_with_compare_count_tb.sv
// testbench for the merge sort block: sorted order, last flag, comparison count and overflow flag
`timescale 1ns / 1ps
module merge_sort_with_compare_count_tb;

   localparam int MAX_ITEMS    = 64;
   localparam int RANDOM_ITEMS = 120;

   typedef logic signed [msc_pkg::DATA_W-1:0] element_type;

   typedef struct {
      element_type                  value;
      logic                         last;
      logic [msc_pkg::CMP_W-1:0]    compares;
      logic                         dropped;
   } sorted_entry_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   element_type               req_value;
   logic                      req_last_in;
   logic                      rsp_valid;
   logic                      rsp_stall;
   element_type               rsp_sorted_value;
   logic                      rsp_last_out;
   logic [msc_pkg::CMP_W-1:0] rsp_comparisons;
   logic                      rsp_dropped;

   // predictor state: the set being loaded and the sorted results still owed
   element_type               loaded_set[$];
   logic                      set_overflowed;
   element_type               sort_work[MAX_ITEMS];
   element_type               merge_tmp[MAX_ITEMS];
   logic [msc_pkg::CMP_W-1:0] merge_compares;
   sorted_entry_type          pending_sorted[$];

   int               error_count;
   bit               sender_gaps;
   bit               receiver_stalls;
   int               hold_request;
   int               hold_left;
   int               stall_left;

   merge_sort_with_compare_count #(
      .MAX_ITEMS(MAX_ITEMS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_comparisons  (rsp_comparisons),
      .rsp_dropped      (rsp_dropped)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic element_type random_element(int mode);
      case (mode)
         0: return element_type'($urandom);
         1: return element_type'(int'($urandom_range(0, 8)) - 4);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 32'sh00000000;
               default: return 32'shFFFFFFFF;
            endcase
         end
      endcase
   endfunction

   function automatic void merge_runs(int lo, int n1, int n2);
      int i;
      int j;
      int k;
      i = lo;
      j = lo + n1;
      k = 0;
      while (i < lo + n1 && j < lo + n1 + n2) begin
         // ties go to the first run
         if (sort_work[i] <= sort_work[j]) begin
            merge_tmp[k] = sort_work[i];
            i++;
         end else begin
            merge_tmp[k] = sort_work[j];
            j++;
         end
         k++;
         if (merge_compares != {msc_pkg::CMP_W{1'b1}}) merge_compares++;
      end
      while (i < lo + n1) begin
         merge_tmp[k] = sort_work[i];
         i++;
         k++;
      end
      while (j < lo + n1 + n2) begin
         merge_tmp[k] = sort_work[j];
         j++;
         k++;
      end
      for (int m = 0; m < k; m++) sort_work[lo + m] = merge_tmp[m];
   endfunction

   function automatic void sort_segment(int lo, int len);
      int first;
      if (len < 2) return;
      first = (len + 1) / 2;
      sort_segment(lo, first);
      sort_segment(lo + first, len - first);
      merge_runs(lo, first, len - first);
   endfunction

   function automatic void predict_sorted_set(element_type elem, logic is_last);
      sorted_entry_type entry;
      int count;
      if (loaded_set.size() < MAX_ITEMS) loaded_set.push_back(elem);
      else set_overflowed = 1'b1;
      if (!is_last) return;
      count = loaded_set.size();
      for (int i = 0; i < count; i++) sort_work[i] = loaded_set[i];
      merge_compares = '0;
      sort_segment(0, count);
      for (int i = 0; i < count; i++) begin
         entry.value    = sort_work[i];
         entry.last     = (i == count - 1);
         entry.compares = merge_compares;
         entry.dropped  = set_overflowed;
         pending_sorted.push_back(entry);
      end
      loaded_set.delete();
      set_overflowed = 1'b0;
   endfunction

   task automatic send_element(element_type elem, logic is_last);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= elem;
      req_last_in <= is_last;
      do @(posedge clock); while (req_stall);
      predict_sorted_set(elem, is_last);
   endtask

   task automatic send_set(element_type elems[$]);
      for (int i = 0; i < elems.size(); i++) send_element(elems[i], i == elems.size() - 1);
   endtask

   task automatic test_single_element();
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      send_set('{32'sh7FFFFFFF});
      send_set('{32'sh80000000});
   endtask

   task automatic test_extremes();
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      send_set('{32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'shFFFFFFFF,
                 32'sh00000001, 32'sh55555555, 32'shAAAAAAAA});
   endtask

   task automatic test_duplicates();
      send_set('{5, -3, 5, 5, -3, 0, 5});
      send_set('{7, 7});
   endtask

   task automatic test_presorted();
      send_set('{-2, -1, 0, 1});
      send_set('{9, 4, 0, -4, -9});
   endtask

   task automatic test_full_store();
      element_type elems[$];
      // exactly full, then three past capacity with the last three items dropped
      for (int i = 0; i < MAX_ITEMS; i++) elems.push_back(random_element(0));
      send_set(elems);
      elems.delete();
      for (int i = 0; i < MAX_ITEMS + 3; i++) elems.push_back(random_element(i % 3));
      send_set(elems);
   endtask

   task automatic test_output_backpressure();
      element_type elems[$];
      sender_gaps = 1'b0;
      for (int i = 0; i < 16; i++) elems.push_back(random_element(0));
      send_set(elems);
      // receiver stops for longer than the sort takes; next set keeps knocking
      hold_request = 1500;
      elems.delete();
      for (int i = 0; i < 16; i++) elems.push_back(random_element(1));
      send_set(elems);
   endtask

   task automatic test_random_sets();
      element_type elems[$];
      int sent;
      int size;
      int roll;
      int mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 78) size = $urandom_range(1, 12);
         else if (roll < 92) size = $urandom_range(13, 40);
         else if (roll < 97) size = $urandom_range(41, MAX_ITEMS);
         else size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
         mode            = $urandom_range(0, 3);
         sender_gaps     = $urandom_range(0, 3) != 0;
         receiver_stalls = $urandom_range(0, 3) != 0;
         elems.delete();
         for (int i = 0; i < size; i++)
            elems.push_back(random_element(mode == 3 ? $urandom_range(0, 2) : mode));
         send_set(elems);
         sent += size;
      end
   endtask

   // result side: check each accepted item, then decide the next stall
   always @(posedge clock) begin : rsp_side
      sorted_entry_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_sorted.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual value %0d",
                        $time, rsp_sorted_value);
               error_count++;
            end else begin
               want = pending_sorted.pop_front();
               if (rsp_sorted_value !== want.value) begin
                  $display("%0t: sorted_value expected %0d actual %0d",
                           $time, want.value, rsp_sorted_value);
                  error_count++;
               end
               if (rsp_last_out !== want.last) begin
                  $display("%0t: last_out expected %0b actual %0b",
                           $time, want.last, rsp_last_out);
                  error_count++;
               end
               if (rsp_comparisons !== want.compares) begin
                  $display("%0t: comparisons expected %0d actual %0d",
                           $time, want.compares, rsp_comparisons);
                  error_count++;
               end
               if (rsp_dropped !== want.dropped) begin
                  $display("%0t: dropped expected %0b actual %0b",
                           $time, want.dropped, rsp_dropped);
                  error_count++;
               end
            end
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = receiver_stalls ? pick_gap() : 0;
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   initial begin
      error_count     = 0;
      set_overflowed  = 1'b0;
      sender_gaps     = 1'b0;
      receiver_stalls = 1'b0;
      hold_request    = 0;
      hold_left       = 0;
      stall_left      = 0;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_value   <= '0;
      req_last_in <= 1'b0;
      rsp_stall   <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_element();
      test_extremes();
      test_duplicates();
      test_presorted();
      test_full_store();
      test_output_backpressure();
      test_random_sets();

      req_valid <= 1'b0;
      while (pending_sorted.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("%0t: timeout", $time);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
rtl/msc_pkg.sv
rtl/msc_ram.sv
rtl/merge_sort_with_compare_count.sv
rtl/msc_checker.sv
tb/merge_sort_with_compare_count_tb.sv
